// ===== design/drq_pkg.sv =====
// ----------------------------------------------------------------------------
// drq_pkg: shared types and constants for the depth range quantizer
// Depth format, derived widths, item kinds and the records that move
// between the range tracker, the prep stages and the divider cells.
// ----------------------------------------------------------------------------
`default_nettype none

package drq_pkg;

    // depth sample format, signed Q16.16 at the default width
    localparam int DEPTH_BITS = 32;

    // d - min and max - min need one more bit than a depth
    localparam int DIFF_W = DEPTH_BITS + 1;
    // magnitudes of those differences fit back into a depth width
    localparam int MAG_W  = DEPTH_BITS;
    // magnitude times 254 needs eight more bits
    localparam int NUM_W  = DEPTH_BITS + 8;
    // quotient bits: eight for the index plus one to flag an overflow
    localparam int QUO_W  = 9;
    localparam int IDX_W  = 8;
    // one divider cell per quotient bit
    localparam int NUM_CELLS = QUO_W;

    // stream widths, rounded up to whole bytes
    localparam int IN_TDATA_W  = ((DEPTH_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((IDX_W + 2 * DEPTH_BITS + 7) / 8) * 8;

    typedef logic signed [DEPTH_BITS-1:0] depth_t;

    // reset values of the running range
    localparam depth_t DEPTH_MAXV = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam depth_t DEPTH_MINV = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    // operation codes carried on tuser
    localparam logic OP_SURVEY = 1'b0;
    localparam logic OP_QUANT  = 1'b1;

    // index codes and the quotient saturation point
    localparam logic [IDX_W-1:0] IDX_NONE = 8'd0;
    localparam logic [IDX_W-1:0] IDX_LOW  = 8'd1;
    localparam logic [IDX_W-1:0] IDX_SAT  = 8'd255;
    localparam logic [QUO_W-1:0] QUO_SAT  = 9'd254;

    // how the index of a request is formed
    typedef enum logic [1:0] {
        KIND_NONE,  // negative depth, index 0
        KIND_ONE,   // zero range, zero offset or differences of opposite sign, index 1
        KIND_DIV    // index from the quotient
    } kind_t;

    // record after the range snapshot
    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0] den;
        logic              neg;
        depth_t            lo;
        depth_t            hi;
        logic              last;
    } snap_t;

    // record handed from cell to cell
    typedef struct packed {
        kind_t             kind;
        logic [NUM_W-1:0]  rem;
        logic [NUM_W-1:0]  dvs;
        logic [QUO_W-1:0]  quo;
        depth_t            lo;
        depth_t            hi;
        logic              last;
    } cell_t;

endpackage

`default_nettype wire

// ===== design/drq_range.sv =====
// ----------------------------------------------------------------------------
// drq_range: running range tracker
// Holds the running minimum and maximum, updates them on survey requests,
// restores them after the last quantize request and registers the range
// snapshot with the two differences for each quantize request.
// ----------------------------------------------------------------------------
`default_nettype none

module drq_range
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              accept,
    input  wire logic              operation,
    input  wire drq_pkg::depth_t   depth_value,
    input  wire logic              last,
    output logic                   snap_valid,
    output drq_pkg::snap_t         snap
);

    drq_pkg::depth_t min_reg;
    drq_pkg::depth_t min_next;
    drq_pkg::depth_t max_reg;
    drq_pkg::depth_t max_next;
    logic            snap_valid_reg;
    logic            snap_valid_next;
    drq_pkg::snap_t  snap_reg;
    drq_pkg::snap_t  snap_next;
    logic [drq_pkg::DIFF_W-1:0] d_ext;
    logic [drq_pkg::DIFF_W-1:0] lo_ext;
    logic [drq_pkg::DIFF_W-1:0] hi_ext;

    // range update
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (accept)
        begin
            if (operation == drq_pkg::OP_SURVEY)
            begin
                if (!depth_value[drq_pkg::DEPTH_BITS-1] && (depth_value < min_reg))
                begin
                    min_next = depth_value;
                end
                if (depth_value > max_reg)
                begin
                    max_next = depth_value;
                end
            end
            else if (last)
            begin
                min_next = drq_pkg::DEPTH_MAXV;
                max_next = drq_pkg::DEPTH_MINV;
            end
        end
    end

    // snapshot and differences for a quantize request
    always_comb
    begin
        d_ext  = {depth_value[drq_pkg::DEPTH_BITS-1], depth_value};
        lo_ext = {min_reg[drq_pkg::DEPTH_BITS-1], min_reg};
        hi_ext = {max_reg[drq_pkg::DEPTH_BITS-1], max_reg};
        snap_valid_next = accept && (operation == drq_pkg::OP_QUANT);
        snap_next.diff  = d_ext - lo_ext;
        snap_next.den   = hi_ext - lo_ext;
        snap_next.neg   = depth_value[drq_pkg::DEPTH_BITS-1];
        snap_next.lo    = min_reg;
        snap_next.hi    = max_reg;
        snap_next.last  = last;
    end

    // range and snapshot valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg        <= drq_pkg::DEPTH_MAXV;
            max_reg        <= drq_pkg::DEPTH_MINV;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            if (advance)
            begin
                snap_valid_reg <= snap_valid_next;
            end
        end
    end

    // snapshot payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

`default_nettype wire

// ===== design/drq_prep.sv =====
// ----------------------------------------------------------------------------
// drq_prep: divider operand preparation
// Sorts out the special cases, takes magnitudes of the two differences and
// scales the numerator by 254, then loads the first divider cell record.
// ----------------------------------------------------------------------------
`default_nettype none

module drq_prep
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              snap_valid,
    input  wire drq_pkg::snap_t    snap,
    output logic                   cell_valid,
    output drq_pkg::cell_t         cell_rec
);

    typedef struct packed {
        drq_pkg::kind_t             kind;
        logic [drq_pkg::MAG_W-1:0]  num_mag;
        logic [drq_pkg::MAG_W-1:0]  den_mag;
        drq_pkg::depth_t            lo;
        drq_pkg::depth_t            hi;
        logic                       last;
    } mag_t;

    logic           mag_valid_reg;
    mag_t           mag_reg;
    mag_t           mag_next;
    logic           cell_valid_reg;
    drq_pkg::cell_t cell_reg;
    drq_pkg::cell_t cell_next;
    logic           diff_neg;
    logic           den_neg;
    logic [drq_pkg::DIFF_W-1:0] diff_abs;
    logic [drq_pkg::DIFF_W-1:0] den_abs;
    logic [drq_pkg::NUM_W-1:0]  num_ext;

    // special cases and magnitudes
    always_comb
    begin
        diff_neg = snap.diff[drq_pkg::DIFF_W-1];
        den_neg  = snap.den[drq_pkg::DIFF_W-1];
        diff_abs = diff_neg ? (drq_pkg::DIFF_W'(0) - snap.diff) : snap.diff;
        den_abs  = den_neg ? (drq_pkg::DIFF_W'(0) - snap.den) : snap.den;
        if (snap.neg)
        begin
            mag_next.kind = drq_pkg::KIND_NONE;
        end
        else if ((snap.den == '0) || (snap.diff == '0) || (diff_neg != den_neg))
        begin
            mag_next.kind = drq_pkg::KIND_ONE;
        end
        else
        begin
            mag_next.kind = drq_pkg::KIND_DIV;
        end
        mag_next.num_mag = diff_abs[drq_pkg::MAG_W-1:0];
        mag_next.den_mag = den_abs[drq_pkg::MAG_W-1:0];
        mag_next.lo      = snap.lo;
        mag_next.hi      = snap.hi;
        mag_next.last    = snap.last;
    end

    // numerator times 254, divisor aligned to the top quotient bit
    always_comb
    begin
        num_ext        = drq_pkg::NUM_W'(mag_reg.num_mag);
        cell_next.kind = mag_reg.kind;
        cell_next.rem  = (num_ext << 8) - (num_ext << 1);
        cell_next.dvs  = {mag_reg.den_mag, 8'b0};
        cell_next.quo  = '0;
        cell_next.lo   = mag_reg.lo;
        cell_next.hi   = mag_reg.hi;
        cell_next.last = mag_reg.last;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg  <= 1'b0;
            cell_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mag_valid_reg  <= snap_valid;
            cell_valid_reg <= mag_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg  <= mag_next;
            cell_reg <= cell_next;
        end
    end

    assign cell_valid = cell_valid_reg;
    assign cell_rec   = cell_reg;

endmodule

`default_nettype wire

// ===== design/drq_div_cell.sv =====
// ----------------------------------------------------------------------------
// drq_div_cell: one restoring division step
// Compares the partial remainder with the aligned divisor, subtracts when it
// fits, shifts the quotient bit in and halves the divisor for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module drq_div_cell
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              in_valid,
    input  wire drq_pkg::cell_t    in_cell,
    output logic                   out_valid,
    output drq_pkg::cell_t         out_cell
);

    logic           valid_reg;
    drq_pkg::cell_t cell_reg;
    drq_pkg::cell_t cell_next;
    logic           fits;

    // divide step
    always_comb
    begin
        fits          = (in_cell.rem >= in_cell.dvs);
        cell_next     = in_cell;
        cell_next.rem = fits ? (in_cell.rem - in_cell.dvs) : in_cell.rem;
        cell_next.dvs = in_cell.dvs >> 1;
        cell_next.quo = {in_cell.quo[drq_pkg::QUO_W-2:0], fits};
    end

    // valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

`default_nettype wire

// ===== design/depth_range_quantizer.sv =====
// ----------------------------------------------------------------------------
// depth_range_quantizer: two-pass min/max linear depth quantizer
// Survey requests track the depth range, quantize requests give an 8-bit
// index into that range together with the range itself.
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata                                   tuser       tlast
//  s_axis    in    depth_value                             operation   last
//  m_axis    out   depth_index, range_min, range_max       -           is_last
//
//  One request is taken every cycle while the output is not stalled.
//  A quantize request's result becomes valid after the range
//  snapshot at the accepting edge, two operand stages, nine divider cells
//  and the output register.
//  Survey requests give no result and update the range in the cycle taken.
//  Reset restores the range to its empty values and empties the pipeline.
//  A stalled output freezes the whole chain and holds s_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_range_quantizer
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [drq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // depth_value
    input  wire logic                               s_axis_tuser,   // operation
    input  wire logic                               s_axis_tlast,   // last
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [drq_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,   // depth_index,
                                                                    // range_min, range_max
    output logic                                    m_axis_tlast    // is_last
);

    logic                 advance;
    logic                 accept;
    logic                 snap_valid;
    drq_pkg::snap_t       snap;
    logic                 chain_valid [0:drq_pkg::NUM_CELLS];
    drq_pkg::cell_t       chain_cell  [0:drq_pkg::NUM_CELLS];
    drq_pkg::cell_t       tail;
    logic                 out_valid_reg;
    logic [drq_pkg::IDX_W-1:0] idx_reg;
    logic [drq_pkg::IDX_W-1:0] idx_next;
    drq_pkg::depth_t      lo_reg;
    drq_pkg::depth_t      hi_reg;
    logic                 last_reg;

    // whole chain moves unless the result register is held
    assign advance       = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && advance;
    assign s_axis_tready = advance;

    drq_range u_range
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .accept      (accept),
        .operation   (s_axis_tuser),
        .depth_value (s_axis_tdata[drq_pkg::DEPTH_BITS-1:0]),
        .last        (s_axis_tlast),
        .snap_valid  (snap_valid),
        .snap        (snap)
    );

    drq_prep u_prep
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .snap_valid (snap_valid),
        .snap       (snap),
        .cell_valid (chain_valid[0]),
        .cell_rec   (chain_cell[0])
    );

    // row of divider cells, one quotient bit each
    for (genvar i = 0; i < drq_pkg::NUM_CELLS; i++)
    begin : g_cell
        drq_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_cell   (chain_cell[i]),
            .out_valid (chain_valid[i+1]),
            .out_cell  (chain_cell[i+1])
        );
    end

    assign tail = chain_cell[drq_pkg::NUM_CELLS];

    // index from the quotient and the case kind
    always_comb
    begin
        case (tail.kind)
            drq_pkg::KIND_NONE: idx_next = drq_pkg::IDX_NONE;
            drq_pkg::KIND_DIV:
            begin
                if (tail.quo >= drq_pkg::QUO_SAT)
                begin
                    idx_next = drq_pkg::IDX_SAT;
                end
                else
                begin
                    idx_next = tail.quo[drq_pkg::IDX_W-1:0] + drq_pkg::IDX_LOW;
                end
            end
            default: idx_next = drq_pkg::IDX_LOW;
        endcase
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain_valid[drq_pkg::NUM_CELLS];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_reg  <= idx_next;
            lo_reg   <= tail.lo;
            hi_reg   <= tail.hi;
            last_reg <= tail.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = drq_pkg::OUT_TDATA_W'({hi_reg, lo_reg, idx_reg});
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire
